// ===== rtl/text_mode_display_registers_defines.svh =====
// Assertion macros for the text mode display register block.
`ifndef TEXT_MODE_DISPLAY_REGISTERS_DEFINES_SVH
`define TEXT_MODE_DISPLAY_REGISTERS_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TMDR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text mode display: assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TMDR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text mode display: assertion failed");
`else
`define TMDR_ASSERT_NOW(label, ante, cons)
`define TMDR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/tmdr_pkg.sv =====
// Shared types and constants of the text mode display register block.
package tmdr_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int ADDR_W     = 13;
	localparam int DATA_W     = 8;
	localparam int ROW_PORT_W = 5;
	localparam int COL_PORT_W = 7;

	localparam logic [ADDR_W-1:0] ADDR_COL    = 13'h000;
	localparam logic [ADDR_W-1:0] ADDR_ROW    = 13'h004;
	localparam logic [ADDR_W-1:0] ADDR_COLOUR = 13'h008;
	localparam logic [ADDR_W-1:0] ADDR_STATUS = 13'h00C;
	localparam logic [ADDR_W-1:0] ADDR_RESET  = 13'h010;
	localparam logic [ADDR_W-1:0] ADDR_TOP    = 13'h014;
	localparam int                STORE_BASE  = 'h100;

	localparam logic [DATA_W-1:0] TOP_MAX      = 8'd23;
	localparam logic [DATA_W-1:0] COLOUR_RESET = 8'h07;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_CELL   = 2'd1,
		KIND_FULL   = 2'd2,
		KIND_CURSOR = 2'd3
	} redraw_kind_t;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0]     read_data;
		redraw_kind_t          redraw_kind;
		logic [ROW_PORT_W-1:0] cell_screen_row;
		logic [COL_PORT_W-1:0] cell_column;
		logic [ROW_PORT_W-1:0] cursor_screen_row;
		logic [COL_PORT_W-1:0] cursor_screen_column;
	} result_t;

endpackage

// ===== rtl/tmdr_if.sv =====
// Valid/ready channel interfaces for bus accesses and their results.
interface tmdr_in_if import tmdr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, mode, address, write_data, input ready);
	modport sink (input valid, mode, address, write_data, output ready);
endinterface

interface tmdr_out_if import tmdr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [DATA_W-1:0]     read_data;
	logic [1:0]            redraw_kind;
	logic [ROW_PORT_W-1:0] cell_screen_row;
	logic [COL_PORT_W-1:0] cell_column;
	logic [ROW_PORT_W-1:0] cursor_screen_row;
	logic [COL_PORT_W-1:0] cursor_screen_column;

	modport source (output valid, read_data, redraw_kind, cell_screen_row, cell_column,
		cursor_screen_row, cursor_screen_column, input ready);
	modport sink (input valid, read_data, redraw_kind, cell_screen_row, cell_column,
		cursor_screen_row, cursor_screen_column, output ready);
endinterface

// ===== rtl/tmdr_store.sv =====
// Character/attribute store: one write port, one registered read port, clearing pass.
module tmdr_store import tmdr_pkg::*; #(
	parameter int DEPTH = 2 * DEF_COLUMNS * DEF_ROWS,
	parameter int OFF_W = $clog2(2 * DEF_COLUMNS * DEF_ROWS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [OFF_W-1:0]  rd_off,
	input  logic              wr_en,
	input  logic [OFF_W-1:0]  wr_off,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              clr_start,
	output logic [DATA_W-1:0] rd_data,
	output logic              busy
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              busy_q;
	logic [OFF_W-1:0]  clr_cnt_q;

	// Sweep every entry once after reset and after each reset write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			if (clr_cnt_q == OFF_W'(DEPTH - 1)) begin
				busy_q    <= 1'b0;
				clr_cnt_q <= '0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end else if (clr_start) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem[wr_off] <= wr_data;
		end
		// Forward a write landing on the byte being read in the same cycle.
		if (rd_en) begin
			rd_data_q <= (wr_en && wr_off == rd_off) ? wr_data : mem[rd_off];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

// ===== rtl/tmdr_regs.sv =====
// Control registers and per-access decode: read data, state update and redraw report.
module tmdr_regs import tmdr_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	parameter int OFF_W   = $clog2(2 * DEF_COLUMNS * DEF_ROWS),
	parameter int ROW_W   = $clog2(DEF_ROWS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  item_t             item,
	input  logic              in_store,
	input  logic [OFF_W-1:0]  off,
	input  logic [ROW_W-1:0]  q_est,
	input  logic [DATA_W-1:0] store_byte,
	output result_t           result,
	output logic              wr_en,
	output logic              clr_start
);

	localparam int ColW   = $clog2(COLUMNS);
	localparam int CellW  = OFF_W - 1;
	localparam int RowXW  = ROW_W + 1;
	localparam int LimitW = DATA_W + 1;

	logic [ColW-1:0]   cur_col_q, col_n, cell_col;
	logic [ROW_W-1:0]  cur_row_q, row_n, top_q, top_n, cell_row;
	logic [DATA_W-1:0] colour_q, colour_n, rd;
	logic              upd_q, upd_n, wr_hit, clr_hit;
	redraw_kind_t      kind;
	logic [CellW-1:0]  cell_idx, rem;
	logic [DATA_W-1:0] d;
	logic [LimitW-1:0] d_x;

	function automatic logic [ROW_W-1:0] ring_row(input logic [ROW_W-1:0] row,
		input logic [ROW_W-1:0] top);
		logic [RowXW-1:0] diff;
		diff = {1'b0, row} - {1'b0, top};
		if (diff[ROW_W]) begin
			diff = diff + RowXW'(ROWS);
		end
		return diff[ROW_W-1:0];
	endfunction

	assign d   = item.write_data;
	assign d_x = {1'b0, d};

	always_comb begin
		rd       = '0;
		kind     = KIND_NONE;
		col_n    = cur_col_q;
		row_n    = cur_row_q;
		top_n    = top_q;
		colour_n = colour_q;
		upd_n    = upd_q;
		wr_hit   = 1'b0;
		clr_hit  = 1'b0;
		if (!item.mode) begin
			unique case (item.address)
				ADDR_COL:    rd = DATA_W'(cur_col_q);
				ADDR_ROW:    rd = DATA_W'(cur_row_q);
				ADDR_COLOUR: rd = colour_q;
				ADDR_TOP:    rd = DATA_W'(top_q);
				ADDR_STATUS: begin
					rd    = {6'd0, upd_q, 1'b1};
					upd_n = 1'b0;
				end
				default: begin
					if (in_store) begin
						rd = store_byte;
					end
				end
			endcase
		end else begin
			unique case (item.address)
				ADDR_COL: begin
					if (d_x < LimitW'(COLUMNS) && d != DATA_W'(cur_col_q)) begin
						col_n = d[ColW-1:0];
						kind  = KIND_CURSOR;
					end
				end
				ADDR_ROW: begin
					if (d_x < LimitW'(ROWS) && d != DATA_W'(cur_row_q)) begin
						row_n = d[ROW_W-1:0];
						kind  = KIND_CURSOR;
					end
				end
				ADDR_COLOUR: colour_n = d;
				ADDR_RESET: begin
					col_n   = '0;
					row_n   = '0;
					top_n   = '0;
					upd_n   = 1'b1;
					kind    = KIND_FULL;
					clr_hit = 1'b1;
				end
				ADDR_TOP: begin
					if (d <= TOP_MAX && d_x < LimitW'(ROWS) && d != DATA_W'(top_q)) begin
						top_n = d[ROW_W-1:0];
						upd_n = 1'b1;
						kind  = KIND_FULL;
					end
				end
				default: begin
					if (in_store && store_byte != d) begin
						wr_hit = 1'b1;
						upd_n  = 1'b1;
						kind   = KIND_CELL;
					end
				end
			endcase
		end
	end

	// Finish cell / COLUMNS: the quotient estimate is low by at most one.
	always_comb begin
		cell_idx = off[OFF_W-1:1];
		rem      = cell_idx - CellW'(q_est) * CellW'(COLUMNS);
		cell_row = q_est;
		if (rem >= CellW'(COLUMNS)) begin
			rem      = rem - CellW'(COLUMNS);
			cell_row = q_est + 1'b1;
		end
		cell_col = rem[ColW-1:0];
	end

	always_comb begin
		result.read_data            = rd;
		result.redraw_kind          = kind;
		result.cell_screen_row      = '0;
		result.cell_column          = '0;
		result.cursor_screen_row    = '0;
		result.cursor_screen_column = '0;
		if (kind == KIND_CELL) begin
			result.cell_screen_row = ROW_PORT_W'(ring_row(cell_row, top_n));
			result.cell_column     = COL_PORT_W'(cell_col);
		end
		if (kind != KIND_NONE) begin
			result.cursor_screen_row    = ROW_PORT_W'(ring_row(row_n, top_n));
			result.cursor_screen_column = COL_PORT_W'(col_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			top_q     <= '0;
			colour_q  <= COLOUR_RESET;
			upd_q     <= 1'b0;
		end else if (adv) begin
			cur_col_q <= col_n;
			cur_row_q <= row_n;
			top_q     <= top_n;
			colour_q  <= colour_n;
			upd_q     <= upd_n;
		end
	end

	assign wr_en     = adv && wr_hit;
	assign clr_start = adv && clr_hit;

endmodule

// ===== rtl/text_mode_display_registers.sv =====
// Byte-wide register window of a character display with text store and redraw report.
//
// req carries one bus access per item (mode, address, write_data); rsp returns one
// result item per access (read_data and what the renderer must redraw). Both are
// valid/ready channels; an item moves when valid and ready are high at a clock edge.
// An access is registered in the input stage and its result waits in an output register,
// which offers it on rsp. One access can be taken every cycle while rsp takes results and
// no sweep or reset write holds req.ready low. An access is decoded in the input stage, which
// holds the registered store byte, so store reads and compare-on-write are done there. While
// rsp stalls, one more access is held in the input stage and req.ready drops after that.
// The store has a single write port and is cleared by a sweep of one byte per cycle
// over all 2 * COLUMNS * ROWS bytes (4000 at 80 x 25) after arst_n is released and after each
// write to the reset register. req.ready stays low during the sweep, and also while a
// reset write waits in the input stage.
// arst_n (asynchronous, active low) empties both stages, sets cursor and top row to 0,
// colour to 7 and clears the updated flag; the store sweep starts on release.
`include "text_mode_display_registers_defines.svh"

module text_mode_display_registers import tmdr_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input logic        clk,
	input logic        arst_n,
	tmdr_in_if.sink    req,
	tmdr_out_if.source rsp
);

	localparam int StoreBytes = 2 * COLUMNS * ROWS;
	localparam int OffW       = $clog2(StoreBytes);
	localparam int CellW      = OffW - 1;
	localparam int RowW       = $clog2(ROWS);
	localparam int AddrXW     = ADDR_W + 2;
	localparam int StoreEnd   = STORE_BASE + StoreBytes;
	localparam int QShift     = CellW;
	localparam int QRecip     = (2 ** QShift) / COLUMNS;
	localparam int ProdW      = CellW + QShift;

	logic              acc, adv, clr_busy, reset_s1, wr_en, clr_start;
	logic [AddrXW-1:0] addr_x, off_x;
	logic              in_store_in;
	logic [OffW-1:0]   off_in;
	logic [CellW-1:0]  cell_in;
	logic [ProdW-1:0]  prod;
	logic [RowW-1:0]   q_est_in;
	logic [DATA_W-1:0] store_byte;

	logic              valid_s1, in_store_s1;
	item_t             item_s1;
	logic [OffW-1:0]   off_s1;
	logic [RowW-1:0]   q_est_s1;

	result_t           result, rsp_q;
	logic              out_valid_q;

	// Decode the store offset and estimate its row ahead of the input stage.
	assign addr_x      = AddrXW'(req.address);
	assign in_store_in = addr_x >= AddrXW'(STORE_BASE) && addr_x < AddrXW'(StoreEnd);
	assign off_x       = addr_x - AddrXW'(STORE_BASE);
	assign off_in      = off_x[OffW-1:0];
	assign cell_in     = off_in[OffW-1:1];
	assign prod        = ProdW'(cell_in) * ProdW'(QRecip);
	assign q_est_in    = RowW'(prod >> QShift);

	assign reset_s1  = item_s1.mode && item_s1.address == ADDR_RESET;
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !clr_busy && !(valid_s1 && reset_s1) && (!valid_s1 || adv);
	assign acc       = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1.mode       <= req.mode;
			item_s1.address    <= req.address;
			item_s1.write_data <= req.write_data;
			in_store_s1        <= in_store_in;
			off_s1             <= off_in;
			q_est_s1           <= q_est_in;
		end
	end

	tmdr_store #(
		.DEPTH (StoreBytes),
		.OFF_W (OffW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc && in_store_in),
		.rd_off    (off_in),
		.wr_en     (wr_en),
		.wr_off    (off_s1),
		.wr_data   (item_s1.write_data),
		.clr_start (clr_start),
		.rd_data   (store_byte),
		.busy      (clr_busy)
	);

	tmdr_regs #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.OFF_W   (OffW),
		.ROW_W   (RowW)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item       (item_s1),
		.in_store   (in_store_s1),
		.off        (off_s1),
		.q_est      (q_est_s1),
		.store_byte (store_byte),
		.result     (result),
		.wr_en      (wr_en),
		.clr_start  (clr_start)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid                = out_valid_q;
	assign rsp.read_data            = rsp_q.read_data;
	assign rsp.redraw_kind          = rsp_q.redraw_kind;
	assign rsp.cell_screen_row      = rsp_q.cell_screen_row;
	assign rsp.cell_column          = rsp_q.cell_column;
	assign rsp.cursor_screen_row    = rsp_q.cursor_screen_row;
	assign rsp.cursor_screen_column = rsp_q.cursor_screen_column;

	`TMDR_ASSERT_NOW(a_sweep_blocks_input, clr_busy, !req.ready)
	`TMDR_ASSERT_NEXT(a_reset_write_starts_sweep, adv && reset_s1, clr_busy)
	`TMDR_ASSERT_NOW(a_cell_fields_zero, rsp.valid && rsp.redraw_kind != KIND_CELL, rsp.cell_screen_row == '0 && rsp.cell_column == '0)

endmodule

// ===== dv/text_mode_display_registers_test.sv =====
// Self-checking testbench for the text mode display register block.
module text_mode_display_registers_test import tmdr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS      = DEF_COLUMNS;
	localparam int ROWS         = DEF_ROWS;
	localparam int STORE_BYTES  = 2 * COLUMNS * ROWS;
	localparam int UNMAPPED_TOP = 4351;
	localparam int RANDOM_ITEMS = 1825;
	localparam int CALM_ITEMS   = 150;
	localparam int RESET_EVERY  = 300;
	localparam int HOLD_AT      = 500;
	localparam int LONG_HOLD    = 64;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_CAP    = 40;

	localparam logic ACC_READ  = 1'b0;
	localparam logic ACC_WRITE = 1'b1;

	localparam logic [DATA_W-1:0] STAT_READY   = 8'h01;
	localparam logic [DATA_W-1:0] STAT_UPDATED = 8'h02;

	typedef struct {
		item_t   acc;
		bit      typed;
		result_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tmdr_in_if  acc_if ();
	tmdr_out_if res_if ();

	text_mode_display_registers DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (acc_if),
		.rsp   (res_if)
	);

	always #5 clk = ~clk;

	// display state as the accesses leave it
	logic [DATA_W-1:0]     shadow_text [STORE_BYTES];
	logic [COL_PORT_W-1:0] cur_col;
	logic [ROW_PORT_W-1:0] cur_row;
	logic [ROW_PORT_W-1:0] top_row;
	logic [DATA_W-1:0]     colour;
	bit                    updated;

	result_t   pending_results [$];
	plan_row_t directed_plan [$];
	int        mismatches;
	int        results_seen;
	int        accesses_sent;
	int        cycle_count;
	bit        gaps_on;
	bit        calm;
	bit        hold_request;

	task automatic report_error(string msg);
		if (mismatches < PRINT_CAP)
			$display("[%0t] %s", $time, msg);
		mismatches++;
	endtask

	function automatic result_t quiet_result(logic [DATA_W-1:0] rd);
		result_t r;
		r.read_data            = rd;
		r.redraw_kind          = KIND_NONE;
		r.cell_screen_row      = '0;
		r.cell_column          = '0;
		r.cursor_screen_row    = '0;
		r.cursor_screen_column = '0;
		return r;
	endfunction

	function automatic result_t cursor_at(int row, int col);
		result_t r;
		r = quiet_result('0);
		r.redraw_kind          = KIND_CURSOR;
		r.cursor_screen_row    = ROW_PORT_W'(row);
		r.cursor_screen_column = COL_PORT_W'(col);
		return r;
	endfunction

	function automatic void clear_text_and_cursor();
		foreach (shadow_text[i])
			shadow_text[i] = '0;
		cur_col = '0;
		cur_row = '0;
		top_row = '0;
	endfunction

	function automatic logic [ROW_PORT_W-1:0] ring_row_of(int row);
		return ROW_PORT_W'((row + ROWS - int'(top_row)) % ROWS);
	endfunction

	// Advance the display state by one access and return what it reports.
	function automatic result_t apply_access(item_t a);
		result_t r;
		int      off;
		int      cell_idx;
		bit      in_text;
		r = quiet_result('0);
		off = int'(a.address) - STORE_BASE;
		in_text = off >= 0 && off < STORE_BYTES;
		if (a.mode == ACC_READ) begin
			if (a.address == ADDR_COL)
				r.read_data = DATA_W'(cur_col);
			else if (a.address == ADDR_ROW)
				r.read_data = DATA_W'(cur_row);
			else if (a.address == ADDR_COLOUR)
				r.read_data = colour;
			else if (a.address == ADDR_TOP)
				r.read_data = DATA_W'(top_row);
			else if (a.address == ADDR_STATUS) begin
				r.read_data = STAT_READY | (updated ? STAT_UPDATED : '0);
				updated = 1'b0;
			end else if (in_text)
				r.read_data = shadow_text[off];
		end else if (a.address == ADDR_COL) begin
			if (int'(a.write_data) < COLUMNS && int'(a.write_data) != int'(cur_col)) begin
				cur_col = COL_PORT_W'(a.write_data);
				r.redraw_kind = KIND_CURSOR;
			end
		end else if (a.address == ADDR_ROW) begin
			if (int'(a.write_data) < ROWS && int'(a.write_data) != int'(cur_row)) begin
				cur_row = ROW_PORT_W'(a.write_data);
				r.redraw_kind = KIND_CURSOR;
			end
		end else if (a.address == ADDR_COLOUR) begin
			colour = a.write_data;
		end else if (a.address == ADDR_RESET) begin
			clear_text_and_cursor();
			updated = 1'b1;
			r.redraw_kind = KIND_FULL;
		end else if (a.address == ADDR_TOP) begin
			if (a.write_data <= TOP_MAX && int'(a.write_data) < ROWS &&
					int'(a.write_data) != int'(top_row)) begin
				top_row = ROW_PORT_W'(a.write_data);
				updated = 1'b1;
				r.redraw_kind = KIND_FULL;
			end
		end else if (in_text) begin
			if (shadow_text[off] != a.write_data) begin
				cell_idx = off / 2;
				shadow_text[off] = a.write_data;
				updated = 1'b1;
				r.redraw_kind = KIND_CELL;
				r.cell_screen_row = ring_row_of(cell_idx / COLUMNS);
				r.cell_column = COL_PORT_W'(cell_idx % COLUMNS);
			end
		end
		if (r.redraw_kind != KIND_NONE) begin
			r.cursor_screen_row = ring_row_of(int'(cur_row));
			r.cursor_screen_column = cur_col;
		end
		return r;
	endfunction

	function automatic void add_row(logic m, int addr, int d, bit typed, result_t want);
		plan_row_t row;
		row.acc.mode       = m;
		row.acc.address    = ADDR_W'(addr);
		row.acc.write_data = DATA_W'(d);
		row.typed          = typed;
		row.want           = want;
		directed_plan.push_back(row);
	endfunction

	function automatic logic [ADDR_W-1:0] store_address();
		int sel;
		sel = $urandom_range(0, 9);
		// keep most traffic on a few cells so bytes get rewritten and read back
		if (sel < 5)
			return ADDR_W'(STORE_BASE + $urandom_range(0, 63));
		else if (sel < 7)
			return ADDR_W'(STORE_BASE + STORE_BYTES - 64 + $urandom_range(0, 63));
		return ADDR_W'(STORE_BASE + $urandom_range(0, STORE_BYTES - 1));
	endfunction

	function automatic item_t random_access();
		item_t a;
		int    pick;
		int    sel;
		a.mode       = ACC_WRITE;
		a.address    = ADDR_COL;
		a.write_data = DATA_W'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 3);
		if (pick < 35) begin
			a.address = store_address();
			if (sel < 2)
				a.write_data = DATA_W'($urandom_range(0, 3));
		end else if (pick < 55) begin
			a.mode = ACC_READ;
			a.address = store_address();
		end else if (pick < 63) begin
			a.address = ADDR_COL;
			if (sel == 0)
				a.write_data = DATA_W'($urandom_range(0, COLUMNS - 1));
			else if (sel == 1)
				a.write_data = DATA_W'(cur_col);
			else if (sel == 2)
				a.write_data = DATA_W'($urandom_range(COLUMNS, 255));
		end else if (pick < 70) begin
			a.address = ADDR_ROW;
			if (sel == 0)
				a.write_data = DATA_W'($urandom_range(0, ROWS - 1));
			else if (sel == 1)
				a.write_data = DATA_W'(cur_row);
			else if (sel == 2)
				a.write_data = DATA_W'($urandom_range(ROWS, 255));
		end else if (pick < 75) begin
			a.address = ADDR_TOP;
			if (sel == 0)
				a.write_data = DATA_W'($urandom_range(0, int'(TOP_MAX)));
			else if (sel == 1)
				a.write_data = DATA_W'(top_row);
			else if (sel == 2)
				a.write_data = DATA_W'(int'(TOP_MAX) + 1);
		end else if (pick < 80) begin
			a.address = ADDR_COLOUR;
		end else if (pick < 88) begin
			a.mode = ACC_READ;
			a.address = ADDR_STATUS;
		end else if (pick < 95) begin
			a.mode = ACC_READ;
			if (sel == 0)
				a.address = ADDR_COL;
			else if (sel == 1)
				a.address = ADDR_ROW;
			else if (sel == 2)
				a.address = ADDR_COLOUR;
			else
				a.address = ADDR_TOP;
		end else begin
			a.mode = 1'($urandom_range(0, 1));
			if (sel == 0)
				a.address = ADDR_STATUS;
			else if (sel == 1) begin
				a.mode = ACC_READ;
				a.address = ADDR_RESET;
			end else if (sel == 2)
				a.address = ADDR_W'($urandom_range(STORE_BASE + STORE_BYTES, UNMAPPED_TOP));
			else begin
				a.address = ADDR_W'($urandom_range(0, STORE_BASE - 1));
				// a stray reset write would cost a full store sweep
				if (a.address == ADDR_RESET)
					a.mode = ACC_READ;
			end
		end
		return a;
	endfunction

	task automatic offer(item_t a, bit typed, result_t want);
		result_t r;
		if (accesses_sent % 100 == 0)
			gaps_on = $urandom_range(0, 2) != 0;
		if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
			acc_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		acc_if.valid      <= 1'b1;
		acc_if.mode       <= a.mode;
		acc_if.address    <= a.address;
		acc_if.write_data <= a.write_data;
		@(posedge clk);
		while (!acc_if.ready)
			@(posedge clk);
		r = apply_access(a);
		pending_results.push_back(typed ? want : r);
		accesses_sent++;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[text_mode_display_registers] ERROR");
			$finish;
		end
	end

	// result side: check each item and throttle ready
	initial begin
		result_t got;
		result_t want;
		int      stall_left;
		int      hold_left;
		int      phase_left;
		bit      stalls_on;
		stall_left = 0;
		hold_left = 0;
		phase_left = 0;
		stalls_on = 1'b0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				got.read_data            = res_if.read_data;
				got.redraw_kind          = redraw_kind_t'(res_if.redraw_kind);
				got.cell_screen_row      = res_if.cell_screen_row;
				got.cell_column          = res_if.cell_column;
				got.cursor_screen_row    = res_if.cursor_screen_row;
				got.cursor_screen_column = res_if.cursor_screen_column;
				if (pending_results.size() == 0)
					report_error($sformatf("result %0d arrived with no access pending",
						results_seen));
				else begin
					want = pending_results.pop_front();
					if (got.read_data !== want.read_data)
						report_error($sformatf("result %0d read_data: got %0h, want %0h",
							results_seen, got.read_data, want.read_data));
					if (got.redraw_kind !== want.redraw_kind)
						report_error($sformatf("result %0d redraw_kind: got %0d, want %0d",
							results_seen, got.redraw_kind, want.redraw_kind));
					if (got.cell_screen_row !== want.cell_screen_row)
						report_error($sformatf("result %0d cell_screen_row: got %0d, want %0d",
							results_seen, got.cell_screen_row, want.cell_screen_row));
					if (got.cell_column !== want.cell_column)
						report_error($sformatf("result %0d cell_column: got %0d, want %0d",
							results_seen, got.cell_column, want.cell_column));
					if (got.cursor_screen_row !== want.cursor_screen_row)
						report_error($sformatf("result %0d cursor_screen_row: got %0d, want %0d",
							results_seen, got.cursor_screen_row, want.cursor_screen_row));
					if (got.cursor_screen_column !== want.cursor_screen_column)
						report_error($sformatf(
							"result %0d cursor_screen_column: got %0d, want %0d",
							results_seen, got.cursor_screen_column,
							want.cursor_screen_column));
				end
				results_seen++;
			end
			if (phase_left == 0) begin
				phase_left = 100;
				stalls_on = $urandom_range(0, 2) != 0;
			end
			phase_left--;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else if (!calm && stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				res_if.ready <= 1'b0;
			end else
				res_if.ready <= 1'b1;
		end
	end

	// access side: directed table, then random traffic
	initial begin
		item_t acc;
		arst_n = 1'b0;
		acc_if.valid = 1'b0;
		acc_if.mode = ACC_READ;
		acc_if.address = '0;
		acc_if.write_data = '0;
		mismatches = 0;
		results_seen = 0;
		accesses_sent = 0;
		cycle_count = 0;
		gaps_on = 1'b0;
		calm = 1'b0;
		hold_request = 1'b0;
		clear_text_and_cursor();
		colour = COLOUR_RESET;
		updated = 1'b0;

		add_row(ACC_READ, ADDR_STATUS, 'hA5, 1, quiet_result(STAT_READY));
		add_row(ACC_READ, ADDR_COLOUR, 0, 1, quiet_result(COLOUR_RESET));
		add_row(ACC_READ, ADDR_COL, 'hFF, 1, quiet_result('0));
		add_row(ACC_WRITE, ADDR_COL, COLUMNS - 1, 1, cursor_at(0, COLUMNS - 1));
		add_row(ACC_WRITE, ADDR_COL, COLUMNS, 1, quiet_result('0));
		add_row(ACC_WRITE, ADDR_COL, 255, 1, quiet_result('0));
		add_row(ACC_WRITE, ADDR_ROW, ROWS - 1, 1, cursor_at(ROWS - 1, COLUMNS - 1));
		add_row(ACC_WRITE, ADDR_ROW, ROWS, 1, quiet_result('0));
		add_row(ACC_WRITE, ADDR_ROW, ROWS - 1, 1, quiet_result('0));
		add_row(ACC_WRITE, ADDR_TOP, TOP_MAX, 0, quiet_result('0));
		add_row(ACC_WRITE, ADDR_TOP, TOP_MAX + 1, 1, quiet_result('0));
		add_row(ACC_WRITE, ADDR_TOP, 255, 1, quiet_result('0));
		add_row(ACC_READ, ADDR_TOP, 0, 1, quiet_result(TOP_MAX));
		add_row(ACC_WRITE, STORE_BASE, 255, 0, quiet_result('0));
		add_row(ACC_WRITE, STORE_BASE, 255, 1, quiet_result('0));
		add_row(ACC_WRITE, STORE_BASE + STORE_BYTES - 1, 'h80, 0, quiet_result('0));
		add_row(ACC_READ, STORE_BASE + STORE_BYTES - 1, 0, 1, quiet_result('h80));
		add_row(ACC_READ, ADDR_STATUS, 0, 1, quiet_result(STAT_READY | STAT_UPDATED));
		add_row(ACC_READ, ADDR_STATUS, 0, 1, quiet_result(STAT_READY));
		add_row(ACC_WRITE, ADDR_STATUS, 'hFF, 1, quiet_result('0));
		add_row(ACC_READ, ADDR_RESET, 0, 1, quiet_result('0));
		add_row(ACC_READ, UNMAPPED_TOP, 0, 1, quiet_result('0));
		add_row(ACC_WRITE, STORE_BASE + STORE_BYTES, 'h5A, 1, quiet_result('0));
		add_row(ACC_WRITE, ADDR_COLOUR, 0, 1, quiet_result('0));
		add_row(ACC_READ, ADDR_COLOUR, 0, 1, quiet_result('0));
		add_row(ACC_WRITE, ADDR_RESET, 'hFF, 0, quiet_result('0));
		add_row(ACC_READ, STORE_BASE + STORE_BYTES - 1, 0, 1, quiet_result('0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i])
			offer(directed_plan[i].acc, directed_plan[i].typed, directed_plan[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = n >= RANDOM_ITEMS - CALM_ITEMS;
			// stall the result side long enough to back up the input
			if (n == HOLD_AT)
				hold_request = 1'b1;
			if (n % RESET_EVERY == RESET_EVERY - 1) begin
				acc.mode = ACC_WRITE;
				acc.address = ADDR_RESET;
				acc.write_data = DATA_W'($urandom_range(0, 255));
			end else
				acc = random_access();
			offer(acc, 1'b0, quiet_result('0));
		end
		acc_if.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("[text_mode_display_registers] OK");
		else
			$display("[text_mode_display_registers] ERROR");
		$finish;
	end
endmodule
